/* hdl/lpmd_pkg.sv */
`default_nettype none

package lpmd_pkg;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE       = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH = 1'd1;

    localparam logic [15:0] MAX_LENGTH_RESET = 16'd8192;

    // header byte positions
    localparam logic [2:0] HDR_LEN_LO  = 3'd0;
    localparam logic [2:0] HDR_LEN_HI  = 3'd1;
    localparam logic [2:0] HDR_LEN2_LO = 3'd4;
    localparam logic [2:0] HDR_LEN2_HI = 3'd5;
    localparam logic [2:0] HDR_EPOCH   = 3'd6;

    typedef enum logic [1:0] {
        MODE_FRAMED  = 2'd0,
        MODE_PASS    = 2'd1,
        MODE_DISCARD = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        KIND_PAYLOAD   = 3'd0,
        KIND_EMPTY     = 3'd1,
        KIND_MISMATCH  = 3'd2,
        KIND_TOO_LARGE = 3'd3,
        KIND_PASS      = 3'd4
    } kind_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [7:0]  data;
        logic        last;
        logic [7:0]  epoch;
        logic [15:0] msg_length;
    } result_t;

endpackage

`default_nettype wire

/* hdl/lpmd_framer.sv */
`default_nettype none

module lpmd_framer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [7:0]         in_byte,
    input  wire lpmd_pkg::mode_t    mode,
    input  wire logic [15:0]        max_length,
    output lpmd_pkg::result_t       res
);

    logic [2:0]  header_position_reg, header_position_next;
    logic [15:0] first_length_reg, first_length_next;
    logic [15:0] second_length_reg, second_length_next;
    logic [7:0]  epoch_value_reg, epoch_value_next;
    logic [15:0] bytes_remaining_reg, bytes_remaining_next;
    logic        in_payload_reg, in_payload_next;

    logic [2:0]  pos;
    logic        last;

    always_comb
    begin
        header_position_next = header_position_reg;
        first_length_next    = first_length_reg;
        second_length_next   = second_length_reg;
        epoch_value_next     = epoch_value_reg;
        bytes_remaining_next = bytes_remaining_reg;
        in_payload_next      = in_payload_reg;

        // position 7 never occurs; treat as start of header
        pos  = (header_position_reg == 3'd7) ? lpmd_pkg::HDR_LEN_LO : header_position_reg;
        last = (bytes_remaining_reg <= 16'd1);

        res.valid      = 1'b0;
        res.kind       = lpmd_pkg::KIND_PAYLOAD;
        res.data       = 8'd0;
        res.last       = 1'b0;
        res.msg_length = 16'd0;

        unique case (mode)
            lpmd_pkg::MODE_PASS:
            begin
                res.valid = 1'b1;
                res.kind  = lpmd_pkg::KIND_PASS;
                res.data  = in_byte;
            end
            lpmd_pkg::MODE_FRAMED:
            begin
                if (in_payload_reg)
                begin
                    res.valid            = 1'b1;
                    res.kind             = lpmd_pkg::KIND_PAYLOAD;
                    res.data             = in_byte;
                    res.last             = last;
                    res.msg_length       = first_length_reg;
                    bytes_remaining_next = bytes_remaining_reg - 16'd1;
                    if (last)
                    begin
                        bytes_remaining_next = 16'd0;
                        in_payload_next      = 1'b0;
                        header_position_next = lpmd_pkg::HDR_LEN_LO;
                    end
                end
                else
                begin
                    case (pos)
                        lpmd_pkg::HDR_LEN_LO:  first_length_next[7:0]   = in_byte;
                        lpmd_pkg::HDR_LEN_HI:  first_length_next[15:8]  = in_byte;
                        lpmd_pkg::HDR_LEN2_LO: second_length_next[7:0]  = in_byte;
                        lpmd_pkg::HDR_LEN2_HI: second_length_next[15:8] = in_byte;
                        default: ;
                    endcase

                    if (pos != lpmd_pkg::HDR_EPOCH)
                    begin
                        header_position_next = pos + 3'd1;
                    end
                    else
                    begin
                        // lengths are complete by now, so the registers hold them
                        epoch_value_next     = in_byte;
                        header_position_next = lpmd_pkg::HDR_LEN_LO;
                        if (first_length_reg != second_length_reg)
                        begin
                            res.valid      = 1'b1;
                            res.kind       = lpmd_pkg::KIND_MISMATCH;
                            res.msg_length = first_length_reg;
                        end
                        else if (first_length_reg > max_length)
                        begin
                            res.valid      = 1'b1;
                            res.kind       = lpmd_pkg::KIND_TOO_LARGE;
                            res.msg_length = first_length_reg;
                        end
                        else if (first_length_reg == 16'd0)
                        begin
                            res.valid = 1'b1;
                            res.kind  = lpmd_pkg::KIND_EMPTY;
                            res.last  = 1'b1;
                        end
                        else
                        begin
                            bytes_remaining_next = first_length_reg;
                            in_payload_next      = 1'b1;
                        end
                    end
                end
            end
            default: ; // discard, and the unused code
        endcase

        res.epoch = epoch_value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_position_reg <= 3'd0;
            first_length_reg    <= 16'd0;
            second_length_reg   <= 16'd0;
            epoch_value_reg     <= 8'd0;
            bytes_remaining_reg <= 16'd0;
            in_payload_reg      <= 1'b0;
        end
        else if (accept)
        begin
            header_position_reg <= header_position_next;
            first_length_reg    <= first_length_next;
            second_length_reg   <= second_length_next;
            epoch_value_reg     <= epoch_value_next;
            bytes_remaining_reg <= bytes_remaining_next;
            in_payload_reg      <= in_payload_next;
        end
    end

    a_payload_at_header_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> header_position_reg == 3'd0)
        else $error("payload phase with header partly collected");

    a_payload_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> bytes_remaining_reg != 16'd0)
        else $error("payload phase with no bytes left");

    a_payload_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == lpmd_pkg::MODE_FRAMED && in_payload_reg) |-> res.valid)
        else $error("payload byte produced no result");

    a_last_ends_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res.valid && res.kind == lpmd_pkg::KIND_PAYLOAD && res.last)
        |=> !in_payload_reg)
        else $error("payload phase outlived its last byte");

endmodule

`default_nettype wire

/* hdl/length_prefixed_message_deframer.sv */
// A result transaction appears on the master side in the cycle after the byte is accepted.
// Throughput: one byte per cycle while s_tready is high; the single output register is the only stage.
// s_tready drops only while a result waits in the output register and m_tready is low.
// Reset (rst_n low, asynchronous): header collection restarts, no payload pending,
// mode framed, max_length 8192, output empty.
`default_nettype none

module length_prefixed_message_deframer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // in_byte
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [31:0]                            m_tdata,   // data, epoch, msg_length
    output logic                                   m_tlast,
    output logic [2:0]                             m_tuser,   // kind
    input  wire logic                              cfg_we,
    input  wire logic [lpmd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [lpmd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    lpmd_pkg::mode_t   mode_reg;
    logic [15:0]       max_length_reg;
    logic              m_valid_reg, m_valid_next;
    lpmd_pkg::result_t out_reg;
    lpmd_pkg::result_t res;
    logic              accept;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= lpmd_pkg::MODE_FRAMED;
            max_length_reg <= lpmd_pkg::MAX_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lpmd_pkg::REG_MODE:       mode_reg       <= lpmd_pkg::mode_t'(cfg_data[1:0]);
                lpmd_pkg::REG_MAX_LENGTH: max_length_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    lpmd_framer u_framer (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (s_tdata),
        .mode       (mode_reg),
        .max_length (max_length_reg),
        .res        (res)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (accept)
            m_valid_next = res.valid;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && res.valid)
            out_reg <= res;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_reg.msg_length, out_reg.epoch, out_reg.data};
    assign m_tlast  = out_reg.last;
    assign m_tuser  = out_reg.kind;

endmodule

`default_nettype wire
